// ===== sv/vna_pkg.sv =====
// package: shared types and constants for the vertex normal averaging core
package vna_pkg;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_TRI    = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int POS_W = 16;
  localparam int SUM_W = 24;
  localparam int NRM_W = 16;
  localparam int IDX_W = 10;
  localparam int MAG_W = 41;
  localparam logic signed [SUM_W-1:0] SUM_MAX = 24'sh7FFFFF;
  localparam logic signed [SUM_W-1:0] SUM_MIN = -24'sh800000;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [IDX_W-1:0] idx;
    logic [POS_W-1:0] px;
    logic [POS_W-1:0] py;
    logic [POS_W-1:0] pz;
    logic [IDX_W-1:0] ca;
    logic [IDX_W-1:0] cb;
    logic [IDX_W-1:0] cc;
    logic             bad;
  } item_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_RA, S_RB, S_RC, S_EDGE, S_CR0, S_CR1, S_CR2,
    S_N0, S_N1, S_N2, S_SQ, S_SQ1, S_SQ2, S_SQRT, S_DIV, S_ADD0, S_ADD1, S_ADD2,
    S_ADDW, S_RS, S_RS1, S_OUT, S_CLR
  } state_t;

endpackage

// ===== sv/vertex_normal_averaging_core.sv =====
// top level: averaged vertex normals from face cross products
// a read normalizes the stored sum; a zero sum or an out-of-range index skips the root and divides
// back end: a degenerate triangle adds nothing to the sums; an out-of-range load or triangle is dropped
// the rate is set by the 31-step square root and three divides
// throughput: one item at a time in the back end; the front queue holds four beats
// reset: synchronous, clears queue and state, then one cycle per vertex zeroes the sums
module vertex_normal_averaging_core #(
  parameter int VERTEX_COUNT = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          cmd,
  input  logic [9:0]          vertex_index,
  input  logic [15:0]         pos_x,
  input  logic [15:0]         pos_y,
  input  logic [15:0]         pos_z,
  input  logic [9:0]          corner_a,
  input  logic [9:0]          corner_b,
  input  logic [9:0]          corner_c,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [9:0]          out_index,
  output logic signed [15:0]  norm_x,
  output logic signed [15:0]  norm_y,
  output logic signed [15:0]  norm_z,
  output logic                is_zero
);
  // queue between front and back
  logic           q_valid, q_take;
  vna_pkg::item_t q_item;

  vna_front #(.VERTEX_COUNT(VERTEX_COUNT)) u_front (
    .clk, .rst, .in_valid, .in_stall, .cmd, .vertex_index, .pos_x, .pos_y, .pos_z,
    .corner_a, .corner_b, .corner_c, .q_valid, .q_take, .q_item
  );

  vna_back #(.VERTEX_COUNT(VERTEX_COUNT)) u_back (
    .clk, .rst, .q_valid, .q_take, .q_item, .out_valid, .out_stall, .out_index,
    .norm_x, .norm_y, .norm_z, .is_zero
  );
endmodule

// ===== sv/vna_front.sv =====
// front: accepts beats, flags out-of-range indexes and queues items
module vna_front #(
  parameter int VERTEX_COUNT = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           cmd,
  input  logic [9:0]           vertex_index,
  input  logic [15:0]          pos_x,
  input  logic [15:0]          pos_y,
  input  logic [15:0]          pos_z,
  input  logic [9:0]           corner_a,
  input  logic [9:0]           corner_b,
  input  logic [9:0]           corner_c,
  output logic                 q_valid,
  input  logic                 q_take,
  output vna_pkg::item_t       q_item
);
  localparam int LIM = (VERTEX_COUNT > 1024) ? 1024 : VERTEX_COUNT;
  localparam logic [10:0] LIM_V = 11'(LIM);

  vna_pkg::item_t fifo [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt;
  vna_pkg::item_t it;
  logic push;

  always_comb begin
    it.cmd = cmd;
    it.idx = vertex_index;
    it.px = pos_x;
    it.py = pos_y;
    it.pz = pos_z;
    it.ca = corner_a;
    it.cb = corner_b;
    it.cc = corner_c;
    if (cmd == vna_pkg::CMD_TRI) begin
      it.bad = ({1'b0, corner_a} >= LIM_V) || ({1'b0, corner_b} >= LIM_V) ||
               ({1'b0, corner_c} >= LIM_V);
    end else begin
      it.bad = {1'b0, vertex_index} >= LIM_V;
    end
  end

  assign in_stall = (cnt == 3'd4);
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt != 3'd0);
  assign q_item = fifo[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wp] <= it;
    end
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 2'd1;
      if (q_take) rp <= rp + 2'd1;
      cnt <= cnt + {2'b0, push} - {2'b0, q_take};
    end
  end
endmodule

// ===== sv/vna_back.sv =====
// back: vertex memories, cross product, normalization and sum update
module vna_back #(
  parameter int VERTEX_COUNT = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_take,
  input  vna_pkg::item_t       q_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [9:0]           out_index,
  output logic signed [15:0]   norm_x,
  output logic signed [15:0]   norm_y,
  output logic signed [15:0]   norm_z,
  output logic                 is_zero
);
  localparam int AW = (VERTEX_COUNT > 1024) ? 10 : $clog2(VERTEX_COUNT);
  localparam int DEPTH = (VERTEX_COUNT > 1024) ? 1024 : VERTEX_COUNT;

  logic [47:0] pos_mem [DEPTH];
  logic [71:0] sum_mem [DEPTH];

  vna_pkg::state_t st, st_next;
  vna_pkg::item_t cur;
  logic [47:0] prd;
  logic [71:0] srd;
  logic [AW-1:0] raddr, waddr;
  logic [AW-1:0] clr_addr;
  logic        pwe, swe;
  logic [71:0] wdata;
  logic signed [15:0] pa [3];
  logic signed [15:0] pb [3];
  logic signed [16:0] e1 [3];
  logic signed [16:0] e2 [3];
  logic signed [33:0] p0, p1;
  logic signed [33:0] m0, m1;
  logic signed [34:0] cr [3];
  logic [40:0] mag [3];
  logic        mag_zero;
  logic [2:0]  sgn;
  logic [40:0] mx;
  logic [5:0]  bits;
  logic [29:0] sm [3];
  logic [59:0] sq0, sq1, sq2;
  logic [61:0] l2;
  logic [61:0] rx, rr, rb;
  logic [61:0] rr_nx;
  logic [5:0]  cyc;
  logic [1:0]  ci;
  logic [44:0] num, rem;
  logic [30:0] len;
  logic [14:0] q;
  logic signed [15:0] n [3];
  logic        zero;
  logic [1:0]  k;

  function automatic logic [5:0] msb_bits(input logic [40:0] v);
    logic [5:0] r;
    r = '0;
    for (int i = 0; i < 41; i++) if (v[i]) r = 6'(i + 1);
    return r;
  endfunction

  function automatic logic signed [23:0] sat(input logic signed [23:0] a,
                                            input logic signed [15:0] b);
    logic signed [24:0] s;
    s = 25'(a) + 25'(b);
    if (s > 25'(vna_pkg::SUM_MAX)) return vna_pkg::SUM_MAX;
    if (s < 25'(vna_pkg::SUM_MIN)) return vna_pkg::SUM_MIN;
    return s[23:0];
  endfunction

  function automatic logic [15:0] q_fin(input logic [44:0] r, input logic [44:0] nm,
                                        input logic [30:0] l, input logic [14:0] qq);
    logic [44:0] t;
    t = {r[43:0], nm[44]};
    return {qq, (t >= 45'(l)) ? 1'b1 : 1'b0};
  endfunction

  // full-width products
  assign m0 = e1[0] * e2[1];
  assign m1 = e1[1] * e2[0];
  assign sq0 = sm[0] * sm[0];
  assign sq1 = sm[1] * sm[1];
  assign sq2 = sm[2] * sm[2];
  assign mag_zero = (mag[0] == '0) && (mag[1] == '0) && (mag[2] == '0);
  // root after the current step
  assign rr_nx = (rx >= rr + rb) ? (rr >> 1) + rb : rr >> 1;

  always_ff @(posedge clk) begin
    if (pwe) pos_mem[waddr] <= {cur.px, cur.py, cur.pz};
    if (swe) sum_mem[waddr] <= wdata;
    prd <= pos_mem[raddr];
    srd <= sum_mem[raddr];
  end

  assign q_take = (st == vna_pkg::S_IDLE) && q_valid;

  always_comb begin
    st_next = st;
    raddr = cur.idx[AW-1:0];
    waddr = cur.idx[AW-1:0];
    pwe = 1'b0;
    swe = 1'b0;
    wdata = '0;
    unique case (st)
      vna_pkg::S_CLR: begin
        waddr = clr_addr;
        swe = 1'b1;
        if (clr_addr == AW'(DEPTH - 1)) st_next = vna_pkg::S_IDLE;
      end
      vna_pkg::S_IDLE: begin
        if (q_valid) begin
          if (q_item.bad && q_item.cmd == vna_pkg::CMD_READ) st_next = vna_pkg::S_OUT;
          else if (q_item.bad) st_next = vna_pkg::S_IDLE;
          else begin
            case (q_item.cmd)
              vna_pkg::CMD_LOAD: st_next = vna_pkg::S_LOAD;
              vna_pkg::CMD_TRI:  st_next = vna_pkg::S_RA;
              vna_pkg::CMD_READ: st_next = vna_pkg::S_RS;
              default:           st_next = vna_pkg::S_IDLE;
            endcase
          end
        end
      end
      vna_pkg::S_LOAD: begin
        pwe = 1'b1;
        swe = 1'b1;
        st_next = vna_pkg::S_IDLE;
      end
      vna_pkg::S_RA: begin raddr = cur.ca[AW-1:0]; st_next = vna_pkg::S_RB; end
      vna_pkg::S_RB: begin raddr = cur.cb[AW-1:0]; st_next = vna_pkg::S_RC; end
      vna_pkg::S_RC: begin raddr = cur.cc[AW-1:0]; st_next = vna_pkg::S_EDGE; end
      vna_pkg::S_EDGE: st_next = vna_pkg::S_CR0;
      vna_pkg::S_CR0: st_next = vna_pkg::S_CR1;
      vna_pkg::S_CR1: st_next = vna_pkg::S_CR2;
      vna_pkg::S_CR2: st_next = vna_pkg::S_N0;
      vna_pkg::S_RS: st_next = vna_pkg::S_RS1;
      vna_pkg::S_RS1: st_next = vna_pkg::S_N0;
      vna_pkg::S_N0: st_next = vna_pkg::S_N1;
      vna_pkg::S_N1: st_next = mag_zero ? ((cur.cmd == vna_pkg::CMD_TRI) ?
                                  vna_pkg::S_IDLE : vna_pkg::S_OUT) : vna_pkg::S_N2;
      vna_pkg::S_N2: st_next = vna_pkg::S_SQ;
      vna_pkg::S_SQ: st_next = vna_pkg::S_SQ1;
      vna_pkg::S_SQ1: st_next = vna_pkg::S_SQ2;
      vna_pkg::S_SQ2: st_next = vna_pkg::S_SQRT;
      vna_pkg::S_SQRT: if (cyc == 6'd30) st_next = vna_pkg::S_DIV;
      vna_pkg::S_DIV: begin
        if (cyc == 6'd15 && ci == 2'd2)
          st_next = (cur.cmd == vna_pkg::CMD_TRI) ? vna_pkg::S_ADD0 : vna_pkg::S_OUT;
      end
      vna_pkg::S_ADD0, vna_pkg::S_ADD1, vna_pkg::S_ADD2: begin
        raddr = (k == 2'd0) ? cur.ca[AW-1:0] : (k == 2'd1) ? cur.cb[AW-1:0] :
                cur.cc[AW-1:0];
        st_next = vna_pkg::S_ADDW;
      end
      vna_pkg::S_ADDW: begin
        waddr = (k == 2'd0) ? cur.ca[AW-1:0] : (k == 2'd1) ? cur.cb[AW-1:0] :
                cur.cc[AW-1:0];
        swe = 1'b1;
        wdata = {sat(srd[71:48], n[0]), sat(srd[47:24], n[1]), sat(srd[23:0], n[2])};
        st_next = (k == 2'd2) ? vna_pkg::S_IDLE : vna_pkg::S_ADD0;
      end
      vna_pkg::S_OUT: if (!out_stall) st_next = vna_pkg::S_IDLE;
      default: st_next = vna_pkg::S_IDLE;
    endcase
  end

  assign out_valid = (st == vna_pkg::S_OUT);
  assign out_index = cur.idx;
  assign norm_x = n[0];
  assign norm_y = n[1];
  assign norm_z = n[2];
  assign is_zero = zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= vna_pkg::S_CLR;
      clr_addr <= '0;
    end else begin
      st <= st_next;
      if (st == vna_pkg::S_CLR) clr_addr <= clr_addr + AW'(1);
    end
    unique case (st)
      vna_pkg::S_IDLE: begin
        cur <= q_item;
        k <= '0;
        zero <= 1'b1;
        for (int i = 0; i < 3; i++) n[i] <= '0;
      end
      vna_pkg::S_RB: begin
        pa[0] <= prd[47:32]; pa[1] <= prd[31:16]; pa[2] <= prd[15:0];
      end
      vna_pkg::S_RC: begin
        pb[0] <= prd[47:32]; pb[1] <= prd[31:16]; pb[2] <= prd[15:0];
      end
      vna_pkg::S_EDGE: begin
        for (int i = 0; i < 3; i++) begin
          e1[i] <= 17'(pb[i]) - 17'(pa[i]);
          e2[i] <= 17'(signed'(prd[47-16*i -: 16])) - 17'(pa[i]);
        end
      end
      vna_pkg::S_CR0: begin
        p0 <= e1[1] * e2[2];
        p1 <= e1[2] * e2[1];
      end
      vna_pkg::S_CR1: begin
        cr[0] <= 35'(p0) - 35'(p1);
        p0 <= e1[2] * e2[0];
        p1 <= e1[0] * e2[2];
      end
      vna_pkg::S_CR2: begin
        cr[1] <= 35'(p0) - 35'(p1);
        cr[2] <= 35'(m0) - 35'(m1);
      end
      vna_pkg::S_RS1: begin
        cr[0] <= 35'(signed'(srd[71:48]));
        cr[1] <= 35'(signed'(srd[47:24]));
        cr[2] <= 35'(signed'(srd[23:0]));
      end
      vna_pkg::S_N0: begin
        for (int i = 0; i < 3; i++) begin
          sgn[i] <= cr[i][34];
          mag[i] <= cr[i][34] ? 41'(-cr[i]) : 41'(cr[i]);
        end
      end
      vna_pkg::S_N1: begin
        mx <= (mag[0] > mag[1]) ? ((mag[0] > mag[2]) ? mag[0] : mag[2]) :
              ((mag[1] > mag[2]) ? mag[1] : mag[2]);
        zero <= mag_zero;
      end
      vna_pkg::S_N2: bits <= msb_bits(mx);
      vna_pkg::S_SQ: begin
        for (int i = 0; i < 3; i++)
          sm[i] <= (bits > 6'd30) ? 30'(mag[i] >> (bits - 6'd30)) :
                   30'(mag[i] << (6'd30 - bits));
      end
      vna_pkg::S_SQ1: l2 <= 62'(sq0) + 62'(sq1);
      vna_pkg::S_SQ2: begin
        rx <= l2 + 62'(sq2);
        rr <= '0;
        rb <= 62'h1 << 60;
        cyc <= '0;
      end
      vna_pkg::S_SQRT: begin
        if (rx >= rr + rb) begin
          rx <= rx - (rr + rb);
        end
        rr <= rr_nx;
        rb <= rb >> 2;
        cyc <= cyc + 6'd1;
        if (cyc == 6'd30) begin
          len <= 31'(rr_nx);
          ci <= '0;
          num <= {1'b0, sm[0], 14'b0} + 45'(rr_nx[30:1]);
          rem <= '0;
          q <= '0;
          cyc <= '0;
        end
      end
      vna_pkg::S_DIV: begin
        // quotient fits in 15 bits; one restoring step per cycle
        if (cyc == 6'd0) begin
          rem <= num >> 15;
          num <= num << 30;
          q <= '0;
          cyc <= 6'd1;
        end else begin
          if ({rem[43:0], num[44]} >= 45'(len)) begin
            rem <= {rem[43:0], num[44]} - 45'(len);
            q <= {q[13:0], 1'b1};
          end else begin
            rem <= {rem[43:0], num[44]};
            q <= {q[13:0], 1'b0};
          end
          num <= num << 1;
          cyc <= cyc + 6'd1;
          if (cyc == 6'd15) begin
            n[ci] <= sgn[ci] ? -16'(q_fin(rem, num, len, q)) : 16'(q_fin(rem, num, len, q));
            ci <= ci + 2'd1;
            cyc <= '0;
            num <= {1'b0, sm[(ci == 2'd0) ? 1 : 2], 14'b0} + 45'(len[30:1]);
          end
        end
      end
      vna_pkg::S_ADDW: k <= k + 2'd1;
      default: ;
    endcase
  end
endmodule
